>>> src/i2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2d_pkg;

  localparam int unsigned ValueW    = 64;
  localparam int unsigned CharW     = 6;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 20;
  localparam int unsigned BcdW      = NumDigits * DigitW;
  localparam int unsigned CntW      = $clog2(NumDigits + 1);
  localparam int unsigned BitCntW   = $clog2(ValueW);

  localparam logic [CharW-1:0]  ChZero    = CharW'(48);
  localparam logic [CharW-1:0]  ChMinus   = CharW'(45);
  localparam logic [DigitW-1:0] DabbleMin = DigitW'(5);
  localparam logic [DigitW-1:0] DabbleAdd = DigitW'(3);
  localparam logic [CntW-1:0]   DigitsAll = CntW'(NumDigits);
  localparam logic [CntW-1:0]   DigitsOne = CntW'(1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic shift;
    logic skip;
    logic emit_sign;
    logic emit_digit;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic top_zero;
    logic last_digit;
    logic neg;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

>>> src/i2d_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface i2d_in_if;
  logic                          valid;
  logic                          ready;
  logic [i2d_pkg::ValueW-1:0]    value;
  logic                          is_signed;

  modport source (output valid, output value, output is_signed, input ready);
  modport sink (input valid, input value, input is_signed, output ready);
endinterface

interface i2d_out_if;
  logic                          valid;
  logic                          ready;
  logic [i2d_pkg::CharW-1:0]     ascii_char;
  logic                          last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink (input valid, input ascii_char, input last, output ready);
endinterface

`default_nettype wire

>>> src/i2d_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module i2d_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  i2d_pkg::ctrl_sts_t sts_i,
  output i2d_pkg::ctrl_cmd_t cmd_o
);
  import i2d_pkg::*;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StConv = 5'b00010,
    StSkip = 5'b00100,
    StSign = 5'b01000,
    StEmit = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [BitCntW-1:0]   bit_cnt_q, bit_cnt_d;

  always_comb begin
    state_d    = state_q;
    bit_cnt_d  = bit_cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          bit_cnt_d  = '0;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.shift = 1'b1;
        bit_cnt_d   = bit_cnt_q + 1'b1;
        if (bit_cnt_q == '1) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        // Drop leading zero digits, but always keep the units digit.
        if (sts_i.top_zero && !sts_i.last_digit) begin
          cmd_o.skip = 1'b1;
        end else if (sts_i.neg) begin
          state_d = StSign;
        end else begin
          state_d = StEmit;
        end
      end
      StSign: begin
        if (sts_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = StEmit;
        end
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (sts_i.last_digit) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      bit_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> src/i2d_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module i2d_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [i2d_pkg::ValueW-1:0]  value_i,
  input  logic                        is_signed_i,
  input  i2d_pkg::ctrl_cmd_t          cmd_i,
  output i2d_pkg::ctrl_sts_t          sts_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [i2d_pkg::CharW-1:0]   out_char_o,
  output logic                        out_last_o
);
  import i2d_pkg::*;

  logic [ValueW-1:0] mag_q, mag_d;
  logic              neg_q, neg_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic [BcdW-1:0]   bcd_adj;
  logic [CntW-1:0]   ndig_q, ndig_d;
  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  out_char_q, out_char_d;
  logic              out_last_q, out_last_d;
  logic              load_neg;
  logic [DigitW-1:0] top_digit;

  assign load_neg  = is_signed_i & value_i[ValueW-1];
  assign top_digit = bcd_q[BcdW-1 -: DigitW];

  // One double-dabble step: every BCD digit of five or more gets three added
  // before the shift, so that it carries correctly into the next digit.
  always_comb begin
    logic [DigitW-1:0] dig;
    for (int i = 0; i < NumDigits; i++) begin
      dig = bcd_q[i*DigitW +: DigitW];
      bcd_adj[i*DigitW +: DigitW] = (dig >= DabbleMin) ? dig + DabbleAdd : dig;
    end
  end

  always_comb begin
    mag_d       = mag_q;
    neg_d       = neg_q;
    bcd_d       = bcd_q;
    ndig_d      = ndig_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (cmd_i.load) begin
      mag_d  = load_neg ? (~value_i + 1'b1) : value_i;
      neg_d  = load_neg;
      bcd_d  = '0;
      ndig_d = DigitsAll;
    end
    if (cmd_i.shift) begin
      bcd_d = {bcd_adj[BcdW-2:0], mag_q[ValueW-1]};
      mag_d = {mag_q[ValueW-2:0], 1'b0};
    end
    if (cmd_i.skip || cmd_i.emit_digit) begin
      bcd_d  = {bcd_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
      ndig_d = ndig_q - 1'b1;
    end
    if (cmd_i.emit_sign) begin
      out_char_d  = ChMinus;
      out_last_d  = 1'b0;
      out_valid_d = 1'b1;
    end
    if (cmd_i.emit_digit) begin
      out_char_d  = ChZero + {{(CharW-DigitW){1'b0}}, top_digit};
      out_last_d  = (ndig_q == DigitsOne);
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    bcd_q      <= bcd_d;
    ndig_q     <= ndig_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign sts_o.top_zero   = (top_digit == '0);
  assign sts_o.last_digit = (ndig_q == DigitsOne);
  assign sts_o.neg        = neg_q;
  assign sts_o.out_free   = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

>>> src/int64_to_decimal_ascii_top.sv
// Converts a 64-bit value to its decimal ASCII text, one character per beat.
// Input channel in_i carries value and is_signed; with is_signed set the value
// is read as two's complement and a negative number is sent with a leading '-'.
// Output channel out_o carries ascii_char and last, most significant character
// first, with last set on the units digit. Zero gives the single character '0'
// and no leading zeros are sent.
// An accepted value passes a 64-step bit-serial double-dabble conversion into
// 20 BCD digits; then leading zero digits are dropped (up to 19), and then
// each character is sent as the receiver takes it. The input is ready again
// in the cycle after the last character is emitted, while that character may
// still sit in the output register.
// When the receiver stalls, the output register holds its beat and the next
// character waits; nothing is lost.
// Reset (rst_ni, asynchronous, active low) returns the controller to idle and
// drops any pending output beat.
`timescale 1ns / 1ps
`default_nettype none

module int64_to_decimal_ascii_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  i2d_in_if.sink    in_i,
  i2d_out_if.source out_o
);
  import i2d_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  i2d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  i2d_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (in_i.value),
    .is_signed_i (in_i.is_signed),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_char_o  (out_o.ascii_char),
    .out_last_o  (out_o.last)
  );

`ifndef ASSERT_OFF
  // Once a value is taken, the block is busy converting it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input accepted again straight after a beat");

  // Only a minus sign or a decimal digit is ever sent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.ascii_char == ChMinus ||
                     (out_o.ascii_char >= ChZero && out_o.ascii_char <= ChZero + 6'd9)))
    else $error("output character out of range");

  // The sign is never the final character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ascii_char == ChMinus |-> !out_o.last)
    else $error("minus sign marked as last");

  // Datapath commands are mutually exclusive.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.shift, cmd.skip, cmd.emit_sign, cmd.emit_digit}))
    else $error("more than one datapath command in a cycle");
`endif

endmodule

`default_nettype wire
